// ----- rtl/uer_pkg.sv -----
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// used by every module of the block but uer_range; depends on nothing

package uer_pkg;

   // configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 20;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_HOLDOFF      = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TRIGGER      = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LISTEN_LIMIT = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SCALE        = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MAX_DIST     = 3'd4;

   // register reset values
   localparam logic [19:0] HOLDOFF_RESET      = 20'd80000;
   localparam logic [9:0]  TRIGGER_RESET      = 10'd10;
   localparam logic [15:0] LISTEN_LIMIT_RESET = 16'd38000;
   localparam logic [19:0] SCALE_RESET        = 20'd287981;
   localparam logic [15:0] MAX_DIST_RESET     = 16'd61440;

   // stream widths
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 24;

   // phase tick counter width
   localparam int TICK_BITS = 20;

   typedef struct packed {
      logic [19:0] holdoff_ticks;
      logic [9:0]  trigger_ticks;
      logic [15:0] listen_limit_ticks;
      logic [19:0] scale_q16;
      logic [15:0] max_distance_q8;
   } uer_cfg_type;

   typedef struct packed {
      logic [15:0] distance_q8;
      logic        distance_valid;
      logic        busy_res;
      logic        trigger_level;
   } uer_result_type;

endpackage

// ----- rtl/ultrasonic_echo_ranger.sv -----
// ultrasonic_echo_ranger: top level of the ultrasonic echo ranger
// each req transfer yields one result on rsp, registered in uer_skid (output or skid register)
// throughput: one tick per cycle while req_tready is high; the sequencer state updates on each accepted tick
// a two-entry result buffer keeps req open while one result waits on rsp
// reset (synchronous, active high) returns to idle and reloads the registers
// depends on uer_pkg, uer_csr, uer_core, uer_range and uer_skid

module ultrasonic_echo_ranger #(
   parameter int READINGS        = 3,
   parameter int ECHO_COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [uer_pkg::REQ_DATA_BITS-1:0] req_tdata,  // echo_level, start_req
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // trigger_level, busy_res, distance_valid, distance_q8[15:0]
   output logic [uer_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // configuration writes
   input  logic                              csr_wr_en,
   input  logic [uer_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import uer_pkg::*;

   uer_cfg_type    cfg;
   uer_result_type core_result;
   uer_result_type rsp_result;
   logic           tick_en;

   assign tick_en = req_tvalid && req_tready;

   uer_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   uer_core #(
      .READINGS        (READINGS),
      .ECHO_COUNT_BITS (ECHO_COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (tick_en),
      .echo_level (req_tdata[0]),
      .start_req  (req_tdata[1]),
      .cfg        (cfg),
      .result     (core_result)
   );

   uer_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (core_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   // pack the result fields from the lowest bit up
   assign rsp_tdata = {5'b0, rsp_result.distance_q8, rsp_result.distance_valid,
                       rsp_result.busy_res, rsp_result.trigger_level};

endmodule

// ----- rtl/uer_csr.sv -----
// uer_csr: configuration register bank of the echo ranger
// depends on uer_pkg for the register indexes and reset values

module uer_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [uer_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output uer_pkg::uer_cfg_type               cfg
);
   import uer_pkg::*;

   uer_cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_HOLDOFF:      cfg_in.holdoff_ticks      = csr_wdata[19:0];
            CSR_TRIGGER:      cfg_in.trigger_ticks      = csr_wdata[9:0];
            CSR_LISTEN_LIMIT: cfg_in.listen_limit_ticks = csr_wdata[15:0];
            CSR_SCALE:        cfg_in.scale_q16          = csr_wdata[19:0];
            CSR_MAX_DIST:     cfg_in.max_distance_q8    = csr_wdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.holdoff_ticks      <= HOLDOFF_RESET;
         cfg_ff.trigger_ticks      <= TRIGGER_RESET;
         cfg_ff.listen_limit_ticks <= LISTEN_LIMIT_RESET;
         cfg_ff.scale_q16          <= SCALE_RESET;
         cfg_ff.max_distance_q8    <= MAX_DIST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/uer_range.sv -----
// uer_range: scales an echo width to UQ8.8 centimetres and clamps it
// depends on nothing but its width parameter

module uer_range #(
   parameter int ECHO_COUNT_BITS = 16
) (
   input  logic [ECHO_COUNT_BITS-1:0] echo_width,
   input  logic [19:0]                scale_q16,
   input  logic [15:0]                max_distance_q8,
   output logic [15:0]                distance_q8
);
   localparam int PROD_BITS  = ECHO_COUNT_BITS + 20;
   localparam int SHIFT_BITS = PROD_BITS - 16;

   logic [PROD_BITS-1:0]  product;
   logic [SHIFT_BITS-1:0] scaled;

   // truncating multiply, drop the 16 fraction bits of the scale
   assign product = PROD_BITS'(echo_width) * PROD_BITS'(scale_q16);
   assign scaled  = product[PROD_BITS-1:16];

   // clamp to the ceiling
   assign distance_q8 = (scaled > SHIFT_BITS'(max_distance_q8)) ? max_distance_q8
                                                                : scaled[15:0];

endmodule

// ----- rtl/uer_core.sv -----
// uer_core: per-tick sequencer of the echo ranger (holdoff, trigger, listen)
// depends on uer_pkg and uer_range

module uer_core #(
   parameter int READINGS        = 3,
   parameter int ECHO_COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick_en,
   input  logic                   echo_level,
   input  logic                   start_req,
   input  uer_pkg::uer_cfg_type   cfg,
   output uer_pkg::uer_result_type result
);
   import uer_pkg::*;

   localparam int RIDX_BITS = $clog2(READINGS + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HOLDOFF,
      PH_TRIGGER,
      PH_LISTEN
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic [TICK_BITS-1:0]       ticks_ff, ticks_in;
   logic [ECHO_COUNT_BITS-1:0] width_ff, width_in;
   logic                       seen_ff, seen_in;
   logic [RIDX_BITS-1:0]       round_ff, round_in, round_next;
   logic [15:0]                least_ff, least_in;
   logic [15:0]                last_ff, last_in;
   logic                       valid;
   logic                       close;
   logic [15:0]                close_dist;
   logic [15:0]                echo_dist;

   uer_range #(
      .ECHO_COUNT_BITS(ECHO_COUNT_BITS)
   ) u_range (
      .echo_width      (width_ff),
      .scale_q16       (cfg.scale_q16),
      .max_distance_q8 (cfg.max_distance_q8),
      .distance_q8     (echo_dist)
   );

   assign round_next = round_ff + 1'b1;

   // next state for one tick
   always_comb begin
      phase_in   = phase_ff;
      ticks_in   = ticks_ff;
      width_in   = width_ff;
      seen_in    = seen_ff;
      round_in   = round_ff;
      least_in   = least_ff;
      last_in    = last_ff;
      valid      = 1'b0;
      close      = 1'b0;
      close_dist = cfg.max_distance_q8;

      unique case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               round_in = '0;
               least_in = '1;
               phase_in = PH_HOLDOFF;
               ticks_in = '0;
               width_in = '0;
               seen_in  = 1'b0;
            end
         end
         PH_HOLDOFF: begin
            if (ticks_ff >= cfg.holdoff_ticks) begin
               phase_in = PH_TRIGGER;
               ticks_in = '0;
            end else begin
               ticks_in = ticks_ff + 1'b1;
            end
         end
         PH_TRIGGER: begin
            ticks_in = ticks_ff + 1'b1;
            if (ticks_in >= TICK_BITS'(cfg.trigger_ticks)) begin
               phase_in = PH_LISTEN;
               ticks_in = '0;
            end
         end
         PH_LISTEN: begin
            if (ticks_ff != '1) begin
               ticks_in = ticks_ff + 1'b1;
            end
            if (echo_level) begin
               seen_in = 1'b1;
               if (width_ff != '1) begin
                  width_in = width_ff + 1'b1;
               end
               if (ticks_in >= TICK_BITS'(cfg.listen_limit_ticks)) begin
                  close = 1'b1;
               end
            end else if (seen_ff) begin
               // falling echo wins over the timeout
               close      = 1'b1;
               close_dist = echo_dist;
            end else if (ticks_in >= TICK_BITS'(cfg.listen_limit_ticks)) begin
               close = 1'b1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      // end of a round: keep the minimum, then next round or finish
      if (close) begin
         least_in = (close_dist < least_ff) ? close_dist : least_ff;
         if (round_next >= RIDX_BITS'(READINGS)) begin
            last_in  = least_in;
            phase_in = PH_IDLE;
            ticks_in = '0;
            round_in = '0;
            valid    = 1'b1;
         end else begin
            round_in = round_next;
            phase_in = PH_HOLDOFF;
            ticks_in = '0;
            width_in = '0;
            seen_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ticks_ff <= '0;
         width_ff <= '0;
         seen_ff  <= 1'b0;
         round_ff <= '0;
         least_ff <= '1;
         last_ff  <= '0;
      end else if (tick_en) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         width_ff <= width_in;
         seen_ff  <= seen_in;
         round_ff <= round_in;
         least_ff <= least_in;
         last_ff  <= last_in;
      end
   end

   // result reflects the state after this tick
   always_comb begin
      result.trigger_level  = (phase_in == PH_TRIGGER);
      result.busy_res       = (phase_in != PH_IDLE);
      result.distance_valid = valid;
      result.distance_q8    = last_in;
   end

endmodule

// ----- rtl/uer_skid.sv -----
// uer_skid: result register with a skid stage for the response stream
// depends on uer_pkg for the result type

module uer_skid (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  uer_pkg::uer_result_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output uer_pkg::uer_result_type out_data
);
   import uer_pkg::*;

   logic           main_valid_ff, main_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   uer_result_type main_data_ff, main_data_in;
   uer_result_type skid_data_ff, skid_data_in;
   logic           transfer_in;
   logic           main_free;

   assign in_ready    = !skid_valid_ff;
   assign transfer_in = in_valid && in_ready;
   assign main_free   = !main_valid_ff || out_ready;

   // refill the output register from the skid stage first
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = transfer_in;
            main_data_in  = in_data;
         end
      end else if (transfer_in) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

// ----- sim/tb_ultrasonic_echo_ranger.sv -----
// tb_ultrasonic_echo_ranger: self-checking testbench for the ultrasonic echo ranger
// predicts every response tick from its own sequencer model and compares field by field
// depends on uer_pkg and ultrasonic_echo_ranger
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranger;
   import uer_pkg::*;

   localparam int          RANGE_ROUNDS = 3;
   localparam int          ECHO_BITS    = 16;
   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int unsigned PRINT_LIMIT  = 40;

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_HOLDOFF, SEQ_TRIGGER, SEQ_LISTEN} seq_phase_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_wr_en  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   // sequencer model state
   uer_cfg_type   cfg;
   seq_phase_type rng_phase;
   logic [19:0]   phase_count;
   logic [15:0]   echo_count;
   logic          echo_seen;
   int unsigned   round_count;
   logic [15:0]   nearest_q8;
   logic [15:0]   reported_q8;

   uer_result_type pending_readings[$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;
   int unsigned ticks_sent     = 0;
   int unsigned results_seen   = 0;
   int unsigned sequences_done = 0;
   int unsigned csr_writes     = 0;
   int unsigned mismatches     = 0;
   int unsigned cycle_count    = 0;

   ultrasonic_echo_ranger #(
      .READINGS        (RANGE_ROUNDS),
      .ECHO_COUNT_BITS (ECHO_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // sequencer model
   // -------------------------------------------------------------------------

   function automatic void clear_ranger();
      cfg.holdoff_ticks      = HOLDOFF_RESET;
      cfg.trigger_ticks      = TRIGGER_RESET;
      cfg.listen_limit_ticks = LISTEN_LIMIT_RESET;
      cfg.scale_q16          = SCALE_RESET;
      cfg.max_distance_q8    = MAX_DIST_RESET;
      rng_phase   = SEQ_IDLE;
      phase_count = '0;
      echo_count  = '0;
      echo_seen   = 1'b0;
      round_count = 0;
      nearest_q8  = 16'hFFFF;
      reported_q8 = '0;
   endfunction

   function automatic void open_round();
      rng_phase   = SEQ_HOLDOFF;
      phase_count = '0;
      echo_count  = '0;
      echo_seen   = 1'b0;
   endfunction

   // truncated product, then clamped to the ceiling
   function automatic logic [15:0] echo_to_q8(input logic [15:0] width);
      logic [35:0] prod;
      prod = ({20'd0, width} * {16'd0, cfg.scale_q16}) >> 16;
      if (prod > {20'd0, cfg.max_distance_q8})
         prod = {20'd0, cfg.max_distance_q8};
      return prod[15:0];
   endfunction

   // keeps the nearest distance; true when the last round has closed
   function automatic logic finish_round(input logic [15:0] reading_q8);
      if (reading_q8 < nearest_q8)
         nearest_q8 = reading_q8;
      round_count++;
      if (round_count >= RANGE_ROUNDS) begin
         reported_q8 = nearest_q8;
         rng_phase   = SEQ_IDLE;
         phase_count = '0;
         round_count = 0;
         sequences_done++;
         return 1'b1;
      end
      open_round();
      return 1'b0;
   endfunction

   function automatic uer_result_type ranger_tick(input logic echo, input logic start);
      uer_result_type res;
      logic           done;
      logic           closed;
      done   = 1'b0;
      closed = 1'b0;
      case (rng_phase)
         SEQ_IDLE: begin
            if (start) begin
               round_count = 0;
               nearest_q8  = 16'hFFFF;
               open_round();
            end
         end
         SEQ_HOLDOFF: begin
            if (phase_count >= cfg.holdoff_ticks) begin
               rng_phase   = SEQ_TRIGGER;
               phase_count = '0;
            end else begin
               phase_count++;
            end
         end
         SEQ_TRIGGER: begin
            // a zero length still gives one trigger tick
            phase_count++;
            if (phase_count >= {10'd0, cfg.trigger_ticks}) begin
               rng_phase   = SEQ_LISTEN;
               phase_count = '0;
            end
         end
         default: begin
            if (phase_count != 20'hFFFFF)
               phase_count++;
            if (echo) begin
               echo_seen = 1'b1;
               if (echo_count != 16'hFFFF)
                  echo_count++;
            end else if (echo_seen) begin
               // falling echo wins over a timeout on the same tick
               done   = finish_round(echo_to_q8(echo_count));
               closed = 1'b1;
            end
            if (!closed && phase_count >= {4'd0, cfg.listen_limit_ticks})
               done = finish_round(cfg.max_distance_q8);
         end
      endcase
      res.trigger_level  = (rng_phase == SEQ_TRIGGER);
      res.busy_res       = (rng_phase != SEQ_IDLE);
      res.distance_valid = done;
      res.distance_q8    = reported_q8;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // stimulus side
   // -------------------------------------------------------------------------

   task automatic send_tick(input logic echo, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_BITS-2){1'b0}}, start, echo};
      do @(posedge clock); while (!req_tready);
      pending_readings.push_back(ranger_tick(echo, start));
      ticks_sent++;
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr, input int unsigned value);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (addr)
         CSR_HOLDOFF:      cfg.holdoff_ticks      = value[19:0];
         CSR_TRIGGER:      cfg.trigger_ticks      = value[9:0];
         CSR_LISTEN_LIMIT: cfg.listen_limit_ticks = value[15:0];
         CSR_SCALE:        cfg.scale_q16          = value[19:0];
         CSR_MAX_DIST:     cfg.max_distance_q8    = value[15:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   // stop sending and wait for every outstanding response
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // one full measurement from idle; per round: echo low for gap listening ticks,
   // then high for width ticks (zero width means no echo at all)
   task automatic measure(input int unsigned g0, input int unsigned w0,
                          input int unsigned g1, input int unsigned w1,
                          input int unsigned g2, input int unsigned w2,
                          input int unsigned noise_pct, input int unsigned start_pct);
      int unsigned gaps[RANGE_ROUNDS];
      int unsigned widths[RANGE_ROUNDS];
      int unsigned listen_tick;
      logic        echo;
      logic        start;
      gaps[0] = g0;  gaps[1] = g1;  gaps[2] = g2;
      widths[0] = w0; widths[1] = w1; widths[2] = w2;
      send_tick($urandom_range(99) < noise_pct, 1'b1);
      listen_tick = 0;
      while (rng_phase != SEQ_IDLE) begin
         start = ($urandom_range(99) < start_pct);
         if (rng_phase == SEQ_LISTEN) begin
            echo = (listen_tick >= gaps[round_count]) &&
                   (listen_tick < gaps[round_count] + widths[round_count]);
            listen_tick++;
         end else begin
            // echo during holdoff and trigger is ignored by the sequencer
            echo        = ($urandom_range(99) < noise_pct);
            listen_tick = 0;
         end
         send_tick(echo, start);
      end
   endtask

   // -------------------------------------------------------------------------
   // response side
   // -------------------------------------------------------------------------

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch on response %0d: %s got %0d, expected %0d",
                  results_seen, what, got, want);
   endtask

   task automatic check_reading(input uer_result_type got);
      uer_result_type want;
      results_seen++;
      if (pending_readings.size() == 0) begin
         report_mismatch("response with nothing pending, distance_q8", got.distance_q8, 0);
      end else begin
         want = pending_readings.pop_front();
         if (got.trigger_level !== want.trigger_level)
            report_mismatch("trigger_level", got.trigger_level, want.trigger_level);
         if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
         if (got.distance_valid !== want.distance_valid)
            report_mismatch("distance_valid", got.distance_valid, want.distance_valid);
         if (got.distance_q8 !== want.distance_q8)
            report_mismatch("distance_q8", got.distance_q8, want.distance_q8);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_reading(uer_result_type'(rsp_tdata[$bits(uer_result_type)-1:0]));
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending",
                  cycle_count, pending_readings.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------

   // idle ticks straight out of reset show a zero distance; then a measurement
   // on the reset values of every register but a short holdoff
   task automatic test_reset_defaults();
      repeat (3) send_tick($urandom_range(1), 1'b0);
      settle();
      csr_write(CSR_HOLDOFF, 2);
      measure(2, 20, 0, 1, 5, 30, 30, 0);
      settle();
   endtask

   // zero holdoff, zero trigger length, echo already high when listening starts,
   // start requests while busy
   task automatic test_fast_rounds();
      csr_write(CSR_HOLDOFF, 0);
      csr_write(CSR_TRIGGER, 0);
      csr_write(CSR_LISTEN_LIMIT, 200);
      measure(0, 3, 0, 1, 0, 7, 100, 50);
      settle();
      csr_write(CSR_HOLDOFF, 1);
      csr_write(CSR_TRIGGER, 1);
      measure(1, 2, 3, 9, 0, 4, 0, 100);
      settle();
   endtask

   task automatic test_long_trigger();
      csr_write(CSR_TRIGGER, 30);
      csr_write(CSR_HOLDOFF, 3);
      measure(0, 6, 1, 2, 2, 4, 20, 0);
      settle();
      csr_write(CSR_TRIGGER, 2);
   endtask

   // timeouts: zero limit, falling echo on the limit tick, echo still high,
   // no echo, and an echo that falls well inside the largest limit
   task automatic test_listen_timeout();
      csr_write(CSR_LISTEN_LIMIT, 0);
      measure(0, 0, 0, 5, 0, 3, 50, 0);
      settle();
      csr_write(CSR_LISTEN_LIMIT, 1);
      measure(0, 1, 0, 2, 1, 1, 0, 0);
      settle();
      csr_write(CSR_LISTEN_LIMIT, 8);
      measure(0, 7, 2, 6, 0, 0, 0, 0);
      settle();
      csr_write(CSR_LISTEN_LIMIT, 65535);
      measure(0, 40, 1, 4, 0, 9, 0, 0);
      settle();
   endtask

   task automatic test_scale_clamp();
      csr_write(CSR_LISTEN_LIMIT, 30);
      csr_write(CSR_SCALE, 0);
      measure(0, 5, 1, 20, 0, 1, 0, 0);
      settle();
      csr_write(CSR_SCALE, 20'hFFFFF);
      csr_write(CSR_MAX_DIST, 16'hFFFF);
      measure(0, 30, 0, 3, 2, 25, 0, 0);
      settle();
      csr_write(CSR_MAX_DIST, 0);
      measure(0, 10, 0, 20, 0, 0, 0, 0);
      settle();
      csr_write(CSR_MAX_DIST, 1000);
      csr_write(CSR_SCALE, 4 * 287981);
      measure(0, 28, 0, 25, 0, 12, 0, 0);
      settle();
   endtask

   task automatic test_long_holdoff();
      csr_write(CSR_HOLDOFF, 20'h2A);
      csr_write(CSR_TRIGGER, 10);
      csr_write(CSR_LISTEN_LIMIT, 50);
      csr_write(CSR_SCALE, SCALE_RESET);
      csr_write(CSR_MAX_DIST, MAX_DIST_RESET);
      measure(1, 12, 1, 8, 1, 20, 0, 10);
      settle();
   endtask

   task automatic randomise_config();
      csr_write(CSR_HOLDOFF, ($urandom_range(15) == 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(0, 6));
      csr_write(CSR_TRIGGER, ($urandom_range(15) == 0) ? $urandom_range(5, 20)
                                                       : $urandom_range(0, 4));
      csr_write(CSR_LISTEN_LIMIT, $urandom_range(0, 40));
      csr_write(CSR_SCALE, $urandom_range(0, 20'hFFFFF));
      csr_write(CSR_MAX_DIST, $urandom_range(1) ? $urandom_range(0, 400)
                                                : $urandom_range(0, 65535));
   endtask

   // well-formed measurements with random echo shapes, idle noise between them
   task automatic test_random_traffic(input int unsigned s_idle, input int unsigned r_idle,
                                      input int unsigned tick_goal,
                                      input int unsigned seq_goal);
      int unsigned first_tick;
      int unsigned first_seq;
      int unsigned w[RANGE_ROUNDS];
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      first_tick    = ticks_sent;
      first_seq     = sequences_done;
      settle();
      randomise_config();
      while (ticks_sent - first_tick < tick_goal || sequences_done - first_seq < seq_goal) begin
         if ($urandom_range(7) == 0) begin
            settle();
            randomise_config();
         end
         repeat ($urandom_range(3)) send_tick($urandom_range(1), 1'b0);
         foreach (w[i])
            w[i] = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
         measure($urandom_range(4), w[0], $urandom_range(4), w[1], $urandom_range(4), w[2],
                 $urandom_range(60), $urandom_range(40));
      end
      settle();
   endtask

   initial begin
      clear_ranger();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_fast_rounds();
      test_long_trigger();
      test_listen_timeout();
      test_scale_clamp();
      test_long_holdoff();
      test_random_traffic(22, 55, 100, 2);
      test_random_traffic(55, 22, 100, 2);
      test_random_traffic(0, 0, 100, 2);

      repeat (5) @(posedge clock);
      $display("covered %0d ticks and %0d finished measurements over %0d register writes",
               ticks_sent, sequences_done, csr_writes);
      $display("%0d responses checked, %0d field mismatches", results_seen, mismatches);
      if (mismatches == 0 && pending_readings.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
